### src/spse_pkg.sv
// shared types and constants for the sparse polynomial store and evaluator
// field layout of the stream ports, request and result records, opcodes
// no dependencies
package spse_pkg;

   localparam int NUM_POLYS  = 16;
   localparam int MAX_DEGREE = 64;

   // fixed field widths of the stream ports
   localparam int OP_W      = 2;
   localparam int POLY_W    = 4;
   localparam int EXPO_W    = 6;
   localparam int COEF_W    = 32;
   localparam int X_W       = 32;
   localparam int STATUS_W  = 2;
   localparam int VALUE_W   = 64;

   // request tdata layout, lowest bit first
   localparam int POLY_LSB  = 0;
   localparam int EXPO_LSB  = POLY_LSB + POLY_W;
   localparam int COEF_LSB  = EXPO_LSB + EXPO_W;
   localparam int X_LSB     = COEF_LSB + COEF_W;
   localparam int REQ_BITS  = X_LSB + X_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = COEF_W + VALUE_W;

   // internal index widths
   localparam int PIDX_W      = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
   localparam int EXP_W       = $clog2(MAX_DEGREE);
   localparam int COEF_ADDR_W = PIDX_W + EXP_W;
   localparam int COEF_DEPTH  = 2 ** COEF_ADDR_W;
   localparam int VROW_DEPTH  = 2 ** PIDX_W;

   // request queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0]        ROUND_HALF = 64'd32768;
   localparam logic signed [63:0] VALUE_MAX  = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] VALUE_MIN  = {1'b1, {63{1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_EVAL   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic                     poly_ok;
      logic                     exp_ok;
      logic [PIDX_W-1:0]        poly;
      logic [EXP_W-1:0]         exponent;
      logic signed [COEF_W-1:0] coefficient;
      logic signed [X_W-1:0]    x_value;
   } cmd_type;

   typedef struct packed {
      status_type                status;
      logic [COEF_W-1:0]         coefficient_out;
      logic signed [VALUE_W-1:0] value_out;
   } res_type;

endpackage

### src/sparse_polynomial_store_eval_unit.sv
// sparse polynomial store with horner evaluation, top level
// insert, query and clear pass the queue, states idle, exec and done, and the output register
// that drives rsp_tvalid; evaluate adds the six states mag, mullo, mulhi, sum, round and acc
// per multiply-add, h times, h the highest stored exponent. one request runs at a time, the
// next only after the result leaves the done state; a 2-entry queue takes requests while the
// result waits. after reset a pass clears all valid rows; no request is taken until it ends.
module sparse_polynomial_store_eval_unit
   import spse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // poly, exponent, coefficient, x_value, zero pad
   input  logic [OP_W-1:0]       req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // coefficient_out, value_out
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   cmd_type cmd;
   logic    cmd_valid, cmd_pop, wiping;
   res_type res;
   logic    res_valid, res_ready;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;

   spse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .hold       (wiping),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   spse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .wiping    (wiping),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.value_out, rsp_ff.coefficient_out};
   assign rsp_tuser  = rsp_ff.status;

   a_no_request_while_wiping : assert property (
      @(posedge clock) disable iff (reset) wiping |-> !req_tready
   ) else $error("request taken during valid-row clearing");

   a_pop_only_when_queued : assert property (
      @(posedge clock) disable iff (reset) cmd_pop |-> cmd_valid
   ) else $error("back end popped an empty queue");

   a_duplicate_has_no_data : assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_DUPLICATE) |-> rsp_tdata == '0
   ) else $error("duplicate insert result carries data");

endmodule

### src/spse_ram.sv
// generic single write port, single read port ram with registered read
// read data holds until the next read
// no dependencies
module spse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/spse_front.sv
// request front end: unpacks and classifies requests into a short queue
// depends on spse_pkg
module spse_front
   import spse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // poly, exponent, coefficient, x_value, zero pad
   input  logic [OP_W-1:0]       req_tuser,   // op
   input  logic                  hold,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   cmd_type               q_ff [QUEUE_DEPTH];
   cmd_type               q_in [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [POLY_W-1:0]     req_poly;
   logic [EXPO_W-1:0]     req_expo;
   cmd_type               cmd_new;
   logic                  push;

   assign req_poly = req_tdata[EXPO_LSB-1:POLY_LSB];
   assign req_expo = req_tdata[COEF_LSB-1:EXPO_LSB];

   // classify: decode the op and check the indexes against the store size
   always_comb begin
      cmd_new.op          = op_type'(req_tuser);
      cmd_new.poly_ok     = 32'(req_poly) < NUM_POLYS;
      cmd_new.exp_ok      = 32'(req_expo) < MAX_DEGREE;
      cmd_new.poly        = PIDX_W'(req_poly);
      cmd_new.exponent    = EXP_W'(req_expo);
      cmd_new.coefficient = req_tdata[X_LSB-1:COEF_LSB];
      cmd_new.x_value     = req_tdata[REQ_BITS-1:X_LSB];
   end

   assign req_tready = !hold && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != '0;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_in[wr_ptr_ff] = cmd_new;
         wr_ptr_in       = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, cmd_pop})
         2'b10: begin
            count_in = count_ff + 1'b1;
         end
         2'b01: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

### src/spse_back.sv
// execution back end: coefficient table, valid-bit rows, highest exponents
// and the horner sequencer with a shared 32x32 multiplier
// depends on spse_pkg and spse_ram
module spse_back
   import spse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    wiping,
   output logic    res_valid,
   output res_type res,
   input  logic    res_ready
);

   typedef enum logic [9:0] {
      S_WIPE  = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_EXEC  = 10'b0000000100,
      S_MAG   = 10'b0000001000,
      S_MULLO = 10'b0000010000,
      S_MULHI = 10'b0000100000,
      S_SUM   = 10'b0001000000,
      S_ROUND = 10'b0010000000,
      S_ACC   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [PIDX_W-1:0]         wipe_ff, wipe_in;
   cmd_type                   cur_ff, cur_in;
   logic [EXP_W-1:0]          highest_ff [NUM_POLYS];
   logic [EXP_W-1:0]          highest_in [NUM_POLYS];
   logic [EXP_W-1:0]          m_ff, m_in, m_dec;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic signed [VALUE_W-1:0] prod_ff, prod_in;
   logic [63:0]               mag_ff, mag_in;
   logic                      pneg_ff, pneg_in;
   logic                      sat_ff, sat_in;
   logic [31:0]               ux_ff, ux_in;
   logic [63:0]               p0_ff, p0_in;
   logic [63:0]               p1_ff, p1_in;
   logic [95:0]               rnd_ff, rnd_in;
   status_type                status_ff, status_in;
   logic [COEF_W-1:0]         cout_ff, cout_in;

   logic                      c_wr_en, c_rd_en;
   logic [COEF_ADDR_W-1:0]    c_wr_addr, c_rd_addr;
   logic [COEF_W-1:0]         c_rd_data;
   logic                      v_wr_en, v_rd_en;
   logic [PIDX_W-1:0]         v_wr_addr, v_rd_addr;
   logic [MAX_DEGREE-1:0]     v_wr_data, v_rd_data;

   logic                      ins_ok, dup;
   logic [COEF_W-1:0]         top_term, step_term;
   logic [31:0]               mul_a;
   logic [63:0]               mul_res;
   logic                      rnd_big;
   logic [63:0]               rnd_mag;
   logic signed [63:0]        addend, sum;
   logic                      add_ovf;

   spse_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (cur_ff.coefficient),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   spse_ram #(.WIDTH(MAX_DEGREE), .DEPTH(VROW_DEPTH)) u_valid_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_en   (v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   // the valid row read data holds across one evaluation; the coefficient is read anew in each mag state
   assign m_dec     = m_ff - 1'b1;
   assign ins_ok    = cur_ff.poly_ok && cur_ff.exp_ok;
   assign dup       = v_rd_data[cur_ff.exponent];
   assign top_term  = v_rd_data[m_ff] ? c_rd_data : '0;
   assign step_term = v_rd_data[m_dec] ? c_rd_data : '0;

   // one multiplier, low then high half of the accumulator magnitude
   assign mul_a   = (state_ff == S_MULLO) ? mag_ff[31:0] : mag_ff[63:32];
   assign mul_res = mul_a * ux_ff;

   assign rnd_big = |rnd_ff[95:80];
   assign rnd_mag = rnd_ff[79:16];

   assign addend  = {{16{step_term[31]}}, step_term, 16'b0};
   assign sum     = prod_ff + addend;
   assign add_ovf = (prod_ff[63] == addend[63]) && (sum[63] != addend[63]);

   assign wiping    = state_ff == S_WIPE;
   assign res_valid = state_ff == S_DONE;
   assign res.status          = status_ff;
   assign res.coefficient_out = cout_ff;
   assign res.value_out       = (cur_ff.op == OP_EVAL) ? acc_ff : '0;

   always_comb begin
      state_in   = state_ff;
      wipe_in    = wipe_ff;
      cur_in     = cur_ff;
      highest_in = highest_ff;
      m_in       = m_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      mag_in     = mag_ff;
      pneg_in    = pneg_ff;
      sat_in     = sat_ff;
      ux_in      = ux_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      rnd_in     = rnd_ff;
      status_in  = status_ff;
      cout_in    = cout_ff;
      cmd_pop    = 1'b0;
      c_wr_en    = 1'b0;
      c_wr_addr  = {cur_ff.poly, cur_ff.exponent};
      c_rd_en    = 1'b0;
      c_rd_addr  = {cur_ff.poly, m_dec};
      v_wr_en    = 1'b0;
      v_wr_addr  = cur_ff.poly;
      v_wr_data  = '0;
      v_rd_en    = 1'b0;
      v_rd_addr  = cmd.poly;

      case (state_ff)
         S_WIPE: begin
            v_wr_en   = 1'b1;
            v_wr_addr = wipe_ff;
            wipe_in   = wipe_ff + 1'b1;
            if (wipe_ff == PIDX_W'(VROW_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               v_rd_en  = 1'b1;
               c_rd_en  = 1'b1;
               m_in     = highest_ff[cmd.poly];
               if (cmd.op == OP_EVAL) begin
                  c_rd_addr = {cmd.poly, highest_ff[cmd.poly]};
               end else begin
                  c_rd_addr = {cmd.poly, cmd.exponent};
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            cout_in   = '0;
            sat_in    = 1'b0;
            state_in  = S_DONE;
            case (cur_ff.op)
               OP_INSERT: begin
                  if (ins_ok) begin
                     if (dup) begin
                        status_in = ST_DUPLICATE;
                     end else begin
                        v_wr_en   = 1'b1;
                        v_wr_data = v_rd_data | (MAX_DEGREE'(1) << cur_ff.exponent);
                        c_wr_en   = 1'b1;
                        if (cur_ff.exponent > highest_ff[cur_ff.poly]) begin
                           highest_in[cur_ff.poly] = cur_ff.exponent;
                        end
                     end
                  end
               end
               OP_QUERY: begin
                  if (ins_ok && dup) begin
                     cout_in = c_rd_data;
                  end
               end
               OP_EVAL: begin
                  acc_in = '0;
                  ux_in  = cur_ff.x_value[31] ? $unsigned(-cur_ff.x_value)
                                              : $unsigned(cur_ff.x_value);
                  if (cur_ff.poly_ok) begin
                     acc_in = {{16{top_term[31]}}, top_term, 16'b0};
                     if (m_ff != '0) begin
                        state_in = S_MAG;
                     end
                  end
               end
               OP_CLEAR: begin
                  if (cur_ff.poly_ok) begin
                     v_wr_en                 = 1'b1;
                     highest_in[cur_ff.poly] = '0;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MAG: begin
            mag_in   = acc_ff[63] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
            pneg_in  = acc_ff[63] ^ cur_ff.x_value[31];
            c_rd_en  = 1'b1;
            state_in = S_MULLO;
         end
         S_MULLO: begin
            p0_in    = mul_res;
            state_in = S_MULHI;
         end
         S_MULHI: begin
            p1_in    = mul_res;
            p0_in    = p0_ff + ROUND_HALF;
            state_in = S_SUM;
         end
         S_SUM: begin
            rnd_in   = {32'b0, p0_ff} + {p1_ff, 32'b0};
            state_in = S_ROUND;
         end
         S_ROUND: begin
            // round half away from zero already added; now sign and clamp
            if (rnd_big) begin
               sat_in  = 1'b1;
               prod_in = pneg_ff ? VALUE_MIN : VALUE_MAX;
            end else if (pneg_ff) begin
               if (rnd_mag[63] && (|rnd_mag[62:0])) begin
                  sat_in  = 1'b1;
                  prod_in = VALUE_MIN;
               end else begin
                  prod_in = $signed(~rnd_mag + 64'd1);
               end
            end else if (rnd_mag[63]) begin
               sat_in  = 1'b1;
               prod_in = VALUE_MAX;
            end else begin
               prod_in = $signed(rnd_mag);
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            if (add_ovf) begin
               sat_in = 1'b1;
               acc_in = addend[63] ? VALUE_MIN : VALUE_MAX;
            end else begin
               acc_in = sum;
            end
            m_in = m_dec;
            if (m_dec == '0) begin
               status_in = (sat_ff || add_ovf) ? ST_SATURATED : ST_OK;
               state_in  = S_DONE;
            end else begin
               state_in = S_MAG;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_WIPE;
         wipe_ff    <= '0;
         highest_ff <= '{default: '0};
         acc_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         wipe_ff    <= wipe_in;
         highest_ff <= highest_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      m_ff      <= m_in;
      prod_ff   <= prod_in;
      mag_ff    <= mag_in;
      pneg_ff   <= pneg_in;
      sat_ff    <= sat_in;
      ux_ff     <= ux_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      rnd_ff    <= rnd_in;
      status_ff <= status_in;
      cout_ff   <= cout_in;
   end

endmodule
